### hw/rtl/crc8cf_pkg.sv
// Shared types, constants and CRC function of the CRC-8 command framer and checker.
package crc8cf_pkg;

  localparam logic [7:0] CRC_INIT      = 8'h82;
  localparam logic [7:0] CRC_POLY      = 8'h8C;
  localparam logic [7:0] CHECK_STATE   = 8'hE1;
  localparam logic [7:0] CHECK_VERSION = 8'h23;
  localparam logic [7:0] GOOD_LENGTH   = 8'd3;
  localparam logic [7:0] WRITE_LOW     = 8'd2;
  localparam logic [7:0] WRITE_HIGH    = 8'd8;

  localparam logic [7:0] ADDR_RESET    = 8'd144;
  localparam logic [7:0] VERSION_RESET = 8'd0;
  localparam logic [7:0] STATE_RESET   = 8'd1;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_REPLY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ORDER = 2'd1;
  localparam logic [1:0] ST_CRC_ERR   = 2'd2;
  localparam logic [1:0] ST_BAD_LEN   = 2'd3;

  localparam logic [1:0] REG_ADDR    = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_STATE   = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WRITE,
    PH_READ
  } phase_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  order;
    logic [15:0] value;
    logic [7:0]  reply_byte;
  } cmd_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] payload;
    logic [1:0]  payload_count;
  } res_t;

  typedef struct packed {
    logic [7:0] seed;
    logic [7:0] version_code;
    logic [7:0] state_code;
  } cfg_t;

  function automatic logic [7:0] crc_feed(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  localparam logic [7:0] SEED_RESET = crc_feed(CRC_INIT, ADDR_RESET);

  function automatic res_t make_tx(input logic [7:0] b, input logic last);
    res_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_byte  = b;
    r.tx_last  = last;
    return r;
  endfunction

  function automatic res_t make_done(input logic [1:0] st, input logic [15:0] pl,
                                     input logic [1:0] cnt);
    res_t r;
    r = '0;
    r.done_res      = 1'b1;
    r.status        = st;
    r.payload       = pl;
    r.payload_count = cnt;
    return r;
  endfunction

endpackage

### hw/rtl/crc8cf_cfg.sv
// Configuration registers; the address is kept as its precomputed CRC seed.
module crc8cf_cfg import crc8cf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed         <= SEED_RESET;
      cfg.version_code <= VERSION_RESET;
      cfg.state_code   <= STATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ADDR:    cfg.seed         <= crc_feed(CRC_INIT, cfg_data);
        REG_VERSION: cfg.version_code <= cfg_data;
        REG_STATE:   cfg.state_code   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

### hw/rtl/crc8cf_engine.sv
// Input register, frame sequencer and reply checker producing at most one result per step.
module crc8cf_engine import crc8cf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  input  logic advance,
  output logic emit_valid,
  output res_t emit
);

  cmd_t        item;
  logic        item_valid;
  logic [1:0]  seq;
  phase_t      phase;
  logic [1:0]  reply_count;
  logic [7:0]  crc_acc;
  logic [7:0]  frame_crc;
  logic [7:0]  length_byte;
  logic [15:0] payload_store;

  logic [1:0]  seq_next;
  phase_t      phase_next;
  logic [1:0]  reply_count_next;
  logic [7:0]  crc_acc_next;
  logic [7:0]  frame_crc_next;
  logic [7:0]  length_byte_next;
  logic [15:0] payload_store_next;

  logic       step;
  logic       retire;
  logic [7:0] acc_fed;
  logic       write_ok;
  logic       state_hit;
  logic       version_hit;

  assign step        = item_valid && advance;
  assign cmd_ready   = !item_valid || (step && retire);
  assign acc_fed     = crc_feed(crc_acc, item.reply_byte);
  assign write_ok    = (item.order >= WRITE_LOW) && (item.order <= WRITE_HIGH);
  assign state_hit   = item.order == cfg.state_code;
  assign version_hit = item.order == cfg.version_code;

  always_comb begin
    seq_next           = seq;
    phase_next         = phase;
    reply_count_next   = reply_count;
    crc_acc_next       = crc_acc;
    frame_crc_next     = frame_crc;
    length_byte_next   = length_byte;
    payload_store_next = payload_store;
    retire             = 1'b1;
    emit_valid         = 1'b0;
    emit               = '0;
    unique case (item.action)
      ACT_WRITE: begin
        emit_valid = 1'b1;
        if (!write_ok) begin
          emit             = make_done(ST_BAD_ORDER, 16'd0, 2'd0);
          phase_next       = PH_IDLE;
          reply_count_next = 2'd0;
          crc_acc_next     = CRC_INIT;
        end else begin
          retire   = 1'b0;
          seq_next = seq + 2'd1;
          unique case (seq)
            2'd0: begin
              emit             = make_tx(item.order, 1'b0);
              frame_crc_next   = crc_feed(cfg.seed, item.order);
              phase_next       = PH_WRITE;
              reply_count_next = 2'd0;
              crc_acc_next     = cfg.seed;
            end
            2'd1: begin
              emit           = make_tx(item.value[7:0], 1'b0);
              frame_crc_next = crc_feed(frame_crc, item.value[7:0]);
            end
            2'd2: begin
              emit           = make_tx(item.value[15:8], 1'b0);
              frame_crc_next = crc_feed(frame_crc, item.value[15:8]);
            end
            default: begin
              emit     = make_tx(frame_crc, 1'b1);
              retire   = 1'b1;
              seq_next = 2'd0;
            end
          endcase
        end
      end
      ACT_READ: begin
        emit_valid = 1'b1;
        if (!state_hit && !version_hit) begin
          emit             = make_done(ST_BAD_ORDER, 16'd0, 2'd0);
          phase_next       = PH_IDLE;
          reply_count_next = 2'd0;
          crc_acc_next     = CRC_INIT;
        end else if (seq == 2'd0) begin
          emit               = make_tx(item.order, 1'b0);
          retire             = 1'b0;
          seq_next           = 2'd1;
          phase_next         = PH_READ;
          reply_count_next   = 2'd0;
          crc_acc_next       = cfg.seed;
          length_byte_next   = 8'd0;
          payload_store_next = 16'd0;
        end else begin
          emit     = make_tx(state_hit ? CHECK_STATE : CHECK_VERSION, 1'b1);
          seq_next = 2'd0;
        end
      end
      ACT_REPLY: begin
        priority case (phase)
          PH_WRITE: begin
            if (reply_count == 2'd2) begin
              emit_valid       = 1'b1;
              emit             = make_done((acc_fed == 8'd0) ? ST_OK : ST_CRC_ERR,
                                           16'd0, 2'd0);
              phase_next       = PH_IDLE;
              reply_count_next = 2'd0;
              crc_acc_next     = CRC_INIT;
            end else begin
              reply_count_next = reply_count + 2'd1;
              crc_acc_next     = acc_fed;
            end
          end
          PH_READ: begin
            unique case (reply_count)
              2'd0: length_byte_next = item.reply_byte;
              2'd1: payload_store_next[7:0] = item.reply_byte;
              2'd2: payload_store_next[15:8] = item.reply_byte;
              default: begin
              end
            endcase
            if (reply_count == 2'd3) begin
              emit_valid = 1'b1;
              if (acc_fed != 8'd0) begin
                emit = make_done(ST_CRC_ERR, 16'd0, 2'd0);
              end else if (length_byte != GOOD_LENGTH) begin
                emit = make_done(ST_BAD_LEN, 16'd0, 2'd0);
              end else begin
                emit = make_done(ST_OK, payload_store, 2'd2);
              end
              phase_next       = PH_IDLE;
              reply_count_next = 2'd0;
              crc_acc_next     = CRC_INIT;
            end else begin
              reply_count_next = reply_count + 2'd1;
              crc_acc_next     = acc_fed;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    if (!item_valid) begin
      emit_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid    <= 1'b0;
      seq           <= 2'd0;
      phase         <= PH_IDLE;
      reply_count   <= 2'd0;
      crc_acc       <= CRC_INIT;
      length_byte   <= 8'd0;
      payload_store <= 16'd0;
    end else begin
      if (cmd_ready) begin
        item_valid <= cmd_valid;
      end
      if (step) begin
        seq           <= seq_next;
        phase         <= phase_next;
        reply_count   <= reply_count_next;
        crc_acc       <= crc_acc_next;
        length_byte   <= length_byte_next;
        payload_store <= payload_store_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      item <= cmd;
    end
    if (step) begin
      frame_crc <= frame_crc_next;
    end
  end

endmodule

### hw/rtl/crc8_command_framer_checker_top.sv
// A result passes through the input register and then the result register. Reply bytes
// are taken at one beat per cycle while the result register is free. A write command
// sends its order, value bytes and frame CRC, a read command its order and check code,
// one transmit byte per cycle through the single result register while it is free.
// Reset is synchronous and active high: it clears the pipeline and link state and
// restores the configuration registers to their defaults.
module crc8_command_framer_checker_top import crc8cf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t cfg;
  logic out_free;
  logic emit_valid;
  res_t emit;

  assign out_free = !res_valid || res_ready;

  crc8cf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  crc8cf_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .advance    (out_free),
    .emit_valid (emit_valid),
    .emit       (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit_valid) begin
      res <= emit;
    end
  end

endmodule
